@@ hw/rtl/prq_pkg.sv @@
// Shared widths, command codes and cell types of the priority ready queue.
package prq_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int CMD_W         = 2;
    localparam int ID_W          = 16;
    localparam int PRI_W         = 8;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    // One slot of the queue as held by a cell.
    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } t_slot;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic             capture;
        logic [PRI_W-1:0] cmp_pri;
        logic             ins_go;
        logic             pop_go;
        t_slot            new_slot;
    } t_cell_ctl;

endpackage

@@ hw/rtl/prq_cell.sv @@
// One queue cell: holds a slot, flags itself as an insert point and shifts with its neighbors.
module prq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  prq_pkg::t_cell_ctl i_ctl,
    input  logic               i_force_hit,
    input  prq_pkg::t_slot     i_left,
    input  prq_pkg::t_slot     i_right,
    input  logic               i_found,
    output logic               o_found,
    output prq_pkg::t_slot     o_slot,
    output prq_pkg::t_slot     o_next
);

    prq_pkg::t_slot r_slot;
    prq_pkg::t_slot n_slot;
    logic           r_hit;
    logic           n_hit;

    // The new word belongs in front of this cell when the hit is forced, the cell is free or it holds a lower priority.
    always_comb begin
        n_hit = i_force_hit || !r_slot.valid || (i_ctl.cmp_pri > r_slot.pri);
    end

    assign o_found = i_found || r_hit;

    always_comb begin
        n_slot = r_slot;
        if (i_ctl.ins_go) begin
            if (i_found) begin
                n_slot = i_left;
            end else if (r_hit) begin
                n_slot = i_ctl.new_slot;
            end
        end else if (i_ctl.pop_go) begin
            n_slot = i_right;
        end
    end

    // Only the valid bit and the hit flag are cleared at reset; id and priority are loaded before they are read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
            r_hit        <= 1'b0;
        end else begin
            r_slot <= n_slot;
            if (i_ctl.capture) begin
                r_hit <= n_hit;
            end
        end
    end

    assign o_slot = r_slot;
    assign o_next = n_slot;

endmodule

@@ hw/rtl/priority_ready_queue.sv @@
// Top level of the priority ready queue: command sequencer, row of cells and result register.
//
//   channel   direction  handshake                 payload
//   command   in         start high, busy low      i_cmd, i_process_id, i_priority_req
//   result    out        o_valid for one cycle     o_popped_*, o_head_*, o_is_empty, o_dropped
//
// In the cycle a command is accepted, each cell compares the new priority with its own and
// registers whether the new word belongs in front of it. In the following cycle busy is high,
// a one-bit found flag ripples down the row of cells, and every cell loads from its left
// neighbor, the new word, its right neighbor or itself. The result word is registered at the
// end of that cycle and shown for one cycle with o_valid, while the next command may already
// be accepted. After reset the queue is empty; the receiver cannot stall, so nothing ever
// waits on the result side.
module priority_ready_queue #(
    parameter int QUEUE_DEPTH = prq_pkg::DEFAULT_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [prq_pkg::CMD_W-1:0] i_cmd,
    input  logic [prq_pkg::ID_W-1:0]  i_process_id,
    input  logic [prq_pkg::PRI_W-1:0] i_priority_req,
    output logic                      o_valid,
    output logic                      o_popped_valid,
    output logic [prq_pkg::ID_W-1:0]  o_popped_id,
    output logic [prq_pkg::PRI_W-1:0] o_popped_priority,
    output logic [prq_pkg::ID_W-1:0]  o_head_id,
    output logic [prq_pkg::PRI_W-1:0] o_head_priority,
    output logic                      o_is_empty,
    output logic                      o_dropped
);

    // Sequencer states.
    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_APPLY = 1'b1;

    logic r_state;
    logic n_state;

    // The accepted command, held through the apply cycle.
    logic                      r_is_ins;
    logic                      r_is_pop;
    logic                      r_drop;
    prq_pkg::t_slot            r_new;

    logic                      accept;
    logic                      full;
    logic                      cmd_ins;
    prq_pkg::t_cell_ctl        ctl;

    prq_pkg::t_slot            slot   [QUEUE_DEPTH];
    prq_pkg::t_slot            next   [QUEUE_DEPTH];
    logic                      found  [QUEUE_DEPTH+1];

    prq_pkg::t_slot            empty_slot;

    assign busy    = (r_state == ST_APPLY);
    assign accept  = start && !busy;
    // The row fills from the head, so the last cell is occupied exactly when the queue is full.
    assign full    = slot[QUEUE_DEPTH-1].valid;
    assign cmd_ins = (i_cmd == prq_pkg::CMD_INSERT) || (i_cmd == prq_pkg::CMD_PUSH);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (accept) begin
                n_state = ST_APPLY;
            end
            ST_APPLY: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_is_ins <= 1'b0;
            r_is_pop <= 1'b0;
            r_drop   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                // A full queue turns an insert or push into a dropped word with no change.
                r_is_ins <= cmd_ins && !full;
                r_drop   <= cmd_ins && full;
                r_is_pop <= (i_cmd == prq_pkg::CMD_POP);
            end else begin
                r_is_ins <= 1'b0;
                r_is_pop <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_new.valid <= 1'b1;
            r_new.id    <= i_process_id;
            r_new.pri   <= i_priority_req;
        end
    end

    always_comb begin
        empty_slot       = r_new;
        empty_slot.valid = 1'b0;
    end

    always_comb begin
        ctl.capture  = accept;
        ctl.cmp_pri  = i_priority_req;
        ctl.ins_go   = busy && r_is_ins;
        ctl.pop_go   = busy && r_is_pop;
        ctl.new_slot = r_new;
    end

    // The head cell never receives a found flag from the left, so its left input is unused
    // and takes the new word.
    assign found[0] = 1'b0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        prq_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_force_hit ((g == 0) && (i_cmd == prq_pkg::CMD_PUSH)),
            .i_left      ((g == 0) ? r_new : slot[(g == 0) ? 0 : g-1]),
            .i_right     ((g == QUEUE_DEPTH-1) ? empty_slot
                                               : slot[(g == QUEUE_DEPTH-1) ? g : g+1]),
            .i_found     (found[g]),
            .o_found     (found[g+1]),
            .o_slot      (slot[g]),
            .o_next      (next[g])
        );
    end

    // Result register: the head after the command is the head cell's next value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (busy) begin
            o_popped_valid    <= r_is_pop && slot[0].valid;
            o_popped_id       <= (r_is_pop && slot[0].valid) ? slot[0].id  : '0;
            o_popped_priority <= (r_is_pop && slot[0].valid) ? slot[0].pri : '0;
            o_head_id         <= next[0].valid ? next[0].id  : '0;
            o_head_priority   <= next[0].valid ? next[0].pri : '0;
            o_is_empty        <= !next[0].valid;
            o_dropped         <= r_drop;
        end
    end

    // Every accepted command is followed by a result strobe.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> ##1 o_valid)
        else $error("result strobe missing after accepted command");

    // A strobe never lands in the apply cycle of another command.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe overlaps an apply cycle");

    // Occupancy stays packed toward the head.
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !slot[0].valid |-> !slot[QUEUE_DEPTH-1].valid)
        else $error("queue cells not packed toward the head");

    // A command never both drops and pops.
    a_drop_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_dropped && o_popped_valid))
        else $error("dropped and popped in one result");

    // An empty queue reports a zero head.
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_empty |-> (o_head_id == '0) && (o_head_priority == '0))
        else $error("empty queue reports a head");

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the priority ready queue: stimulus, driver, predictor and checker.
`timescale 1ns / 1ps

module tb_top;

    // The testbench runs the block at its default depth and keeps its own copy of the queue
    // at the same depth.
    localparam int DEPTH        = prq_pkg::DEFAULT_DEPTH;
    // Cycles without any accepted word on either side before the run is declared hung.
    // This is far longer than the longest sender gap plus a command, so it leaves a wide
    // margin.
    localparam int IDLE_LIMIT   = 2000;
    // Quiet cycles at the end, so that a stray result word would still be caught.
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_WORDS = 1100;

    // One command word as the stimulus builds it, with the idle gap that follows it.
    typedef struct {
        logic [prq_pkg::CMD_W-1:0] cmd;
        logic [prq_pkg::ID_W-1:0]  id;
        logic [prq_pkg::PRI_W-1:0] pri;
        int unsigned               gap;
    } t_cmd_word;

    // One result word as the block reports it.
    typedef struct packed {
        logic                      popped_valid;
        logic [prq_pkg::ID_W-1:0]  popped_id;
        logic [prq_pkg::PRI_W-1:0] popped_pri;
        logic [prq_pkg::ID_W-1:0]  head_id;
        logic [prq_pkg::PRI_W-1:0] head_pri;
        logic                      is_empty;
        logic                      dropped;
    } t_report;

    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      start          = 1'b0;
    logic [prq_pkg::CMD_W-1:0] i_cmd          = prq_pkg::CMD_NONE;
    logic [prq_pkg::ID_W-1:0]  i_process_id   = '0;
    logic [prq_pkg::PRI_W-1:0] i_priority_req = '0;
    logic                      busy;
    logic                      o_valid;
    logic                      o_popped_valid;
    logic [prq_pkg::ID_W-1:0]  o_popped_id;
    logic [prq_pkg::PRI_W-1:0] o_popped_priority;
    logic [prq_pkg::ID_W-1:0]  o_head_id;
    logic [prq_pkg::PRI_W-1:0] o_head_priority;
    logic                      o_is_empty;
    logic                      o_dropped;

    priority_ready_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_process_id     (i_process_id),
        .i_priority_req   (i_priority_req),
        .o_valid          (o_valid),
        .o_popped_valid   (o_popped_valid),
        .o_popped_id      (o_popped_id),
        .o_popped_priority(o_popped_priority),
        .o_head_id        (o_head_id),
        .o_head_priority  (o_head_priority),
        .o_is_empty       (o_is_empty),
        .o_dropped        (o_dropped)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Command words waiting to be driven, and result words the queue model has predicted
    // but the block has not yet reported.
    t_cmd_word cmd_backlog[$];
    t_report   predicted_reports[$];

    // Reference copy of the ready queue: slot 0 is the head, only slots below ready_count
    // are meaningful.
    logic [prq_pkg::ID_W-1:0]  ready_ids [DEPTH];
    logic [prq_pkg::PRI_W-1:0] ready_pris[DEPTH];
    int                        ready_count = 0;

    int unsigned mismatches   = 0;
    int unsigned idle_cycles  = 0;
    int unsigned steady_left  = 0;
    bit          word_taken   = 1'b0;
    int unsigned gap_left     = 0;

    // Coverage tallies for the closing summary.
    int unsigned n_inserts    = 0;
    int unsigned n_pushes     = 0;
    int unsigned n_pops       = 0;
    int unsigned n_empty_pops = 0;
    int unsigned n_drops      = 0;
    int unsigned n_unused     = 0;
    int unsigned n_full_hits  = 0;
    int unsigned n_results    = 0;

    // Applies one accepted command to the reference queue and returns the result word the
    // block must report for it. An insert goes to the head when the queue is empty or the
    // new priority beats the head; otherwise it lands before the first later slot with a
    // lower priority, or at the tail. This scan starts after the head on purpose, so a
    // push to the front that left the list unsorted is handled just as the block must.
    function automatic t_report schedule_command(logic [prq_pkg::CMD_W-1:0] cmd,
                                                 logic [prq_pkg::ID_W-1:0] id,
                                                 logic [prq_pkg::PRI_W-1:0] pri);
        t_report rep;
        int      pos;
        rep = '0;
        case (cmd)
            prq_pkg::CMD_INSERT, prq_pkg::CMD_PUSH: begin
                if (cmd == prq_pkg::CMD_INSERT) n_inserts++;
                else n_pushes++;
                if (ready_count >= DEPTH) begin
                    rep.dropped = 1'b1;
                    n_drops++;
                end else begin
                    pos = 0;
                    if (cmd == prq_pkg::CMD_INSERT && ready_count > 0 &&
                        pri <= ready_pris[0]) begin
                        // Walk down from the tail so the earliest lower slot wins.
                        pos = ready_count;
                        for (int i = ready_count - 1; i >= 1; i--) begin
                            if (pri > ready_pris[i]) pos = i;
                        end
                    end
                    for (int i = ready_count; i > pos; i--) begin
                        ready_ids[i]  = ready_ids[i-1];
                        ready_pris[i] = ready_pris[i-1];
                    end
                    ready_ids[pos]  = id;
                    ready_pris[pos] = pri;
                    ready_count++;
                    if (ready_count == DEPTH) n_full_hits++;
                end
            end
            prq_pkg::CMD_POP: begin
                n_pops++;
                if (ready_count > 0) begin
                    rep.popped_valid = 1'b1;
                    rep.popped_id    = ready_ids[0];
                    rep.popped_pri   = ready_pris[0];
                    for (int i = 1; i < ready_count; i++) begin
                        ready_ids[i-1]  = ready_ids[i];
                        ready_pris[i-1] = ready_pris[i];
                    end
                    ready_count--;
                end else begin
                    n_empty_pops++;
                end
            end
            default: n_unused++;
        endcase
        if (ready_count > 0) begin
            rep.head_id  = ready_ids[0];
            rep.head_pri = ready_pris[0];
        end
        rep.is_empty = (ready_count == 0);
        return rep;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Gap after a word: mostly none, often a few cycles, now and then a long pause. Steady
    // stretches with no gaps at all are mixed in so back-to-back commands get exercised.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (steady_left > 0) begin
            steady_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            steady_left = $urandom_range(10, 40);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void add_word(logic [prq_pkg::CMD_W-1:0] cmd,
                                     logic [prq_pkg::ID_W-1:0] id,
                                     logic [prq_pkg::PRI_W-1:0] pri, int unsigned gap);
        t_cmd_word w;
        w.cmd = cmd;
        w.id  = id;
        w.pri = pri;
        w.gap = gap;
        cmd_backlog.push_back(w);
    endfunction

    // Driver. All inputs move on the falling edge. A word stays on the bus until the block
    // takes it; after that the chosen gap is served before the next word goes out.
    always @(negedge i_clk) begin : driver
        t_cmd_word w;
        if (i_rst_n && !(start && !word_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
                w = cmd_backlog.pop_front();
                i_cmd          <= w.cmd;
                i_process_id   <= w.id;
                i_priority_req <= w.pri;
                start          <= 1'b1;
                gap_left       = w.gap;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor and checker. On each rising edge it first checks any result word against the
    // oldest prediction, then records whether a command word was taken and, if so, predicts
    // its result. The result of a command cannot appear at the edge that takes it, so the
    // order within this block is safe. The watchdog lives here too; a result word only
    // counts as progress when a command was waiting for it.
    always @(posedge i_clk) begin : monitor
        t_report want;
        bit      result_taken;
        if (i_rst_n) begin
            result_taken = 1'b0;
            if (o_valid) begin
                n_results++;
                if (predicted_reports.size() == 0) begin
                    $error("result word with no command outstanding");
                    mismatches++;
                end else begin
                    result_taken = 1'b1;
                    want = predicted_reports.pop_front();
                    check_field("popped_valid",    32'(want.popped_valid),
                                32'(o_popped_valid));
                    check_field("popped_id",       32'(want.popped_id),
                                32'(o_popped_id));
                    check_field("popped_priority", 32'(want.popped_pri),
                                32'(o_popped_priority));
                    check_field("head_id",         32'(want.head_id),
                                32'(o_head_id));
                    check_field("head_priority",   32'(want.head_pri),
                                32'(o_head_priority));
                    check_field("is_empty",        32'(want.is_empty),
                                32'(o_is_empty));
                    check_field("dropped",         32'(want.dropped),
                                32'(o_dropped));
                end
            end
            word_taken = start && !busy;
            if (word_taken) begin
                predicted_reports.push_back(schedule_command(i_cmd, i_process_id,
                                                             i_priority_req));
            end
            if (word_taken || result_taken) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no word accepted for %0d cycles", IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Stimulus: a directed opening, then random phases that fill, drain or churn the queue,
    // then the final wait and verdict.
    initial begin : stimulus
        int unsigned               placed;
        int unsigned               phase_len;
        int unsigned               phase_mode;
        int unsigned               roll;
        int unsigned               pri_base;
        bit                        narrow_pri;
        logic [prq_pkg::CMD_W-1:0] c;
        logic [prq_pkg::PRI_W-1:0] p;

        // Directed part. Pop and an unused command on an empty queue come first.
        add_word(prq_pkg::CMD_POP,  16'h0000, 8'h00, 0);
        add_word(prq_pkg::CMD_NONE, 16'hFFFF, 8'hFF, 1);
        // Extremes of id and priority, a tie at the top that must stay in arrival order,
        // a push that leaves the list unsorted, and an insert that beats that pushed head.
        add_word(prq_pkg::CMD_INSERT, 16'hFFFF, 8'h00, 0);
        add_word(prq_pkg::CMD_INSERT, 16'h0000, 8'hFF, 0);
        add_word(prq_pkg::CMD_INSERT, 16'h1111, 8'hFF, 2);
        add_word(prq_pkg::CMD_PUSH,   16'h2222, 8'h00, 0);
        add_word(prq_pkg::CMD_INSERT, 16'h3333, 8'h80, 0);
        add_word(prq_pkg::CMD_INSERT, 16'h4444, 8'h80, 0);
        add_word(prq_pkg::CMD_PUSH,   16'hAAAA, 8'hFF, 0);
        add_word(prq_pkg::CMD_INSERT, 16'h5555, 8'h01, 0);
        // Fill the rest of the queue so it is exactly full.
        for (int i = 0; i < DEPTH - 8; i++) begin
            add_word((i % 3 == 2) ? prq_pkg::CMD_PUSH : prq_pkg::CMD_INSERT,
                     16'(16'h6000 + i), 8'(i * 37), 0);
        end
        // Insert and push into a full queue are refused; an unused command changes nothing.
        add_word(prq_pkg::CMD_INSERT, 16'hBEEF, 8'hFF, 0);
        add_word(prq_pkg::CMD_PUSH,   16'hCAFE, 8'h00, 3);
        add_word(prq_pkg::CMD_NONE,   16'h0000, 8'h00, 0);
        add_word(prq_pkg::CMD_POP,    16'h0000, 8'h00, 0);
        add_word(prq_pkg::CMD_POP,    16'hFFFF, 8'hFF, 0);

        // Random part. Each phase leans toward filling, draining or a mix, so the queue
        // swings between empty and full many times. Some phases keep priorities in a narrow
        // band so that ties, and ordering among equal priorities, come up often.
        placed = 0;
        while (placed < RANDOM_WORDS) begin
            phase_len  = $urandom_range(8, 40);
            phase_mode = $urandom_range(0, 2);
            narrow_pri = 1'($urandom_range(0, 1));
            pri_base   = $urandom_range(0, 252);
            for (int n = 0; n < phase_len; n++) begin
                roll = $urandom_range(0, 99);
                case (phase_mode)
                    0: c = (roll < 65) ? prq_pkg::CMD_INSERT :
                           (roll < 85) ? prq_pkg::CMD_PUSH :
                           (roll < 96) ? prq_pkg::CMD_POP : prq_pkg::CMD_NONE;
                    1: c = (roll < 75) ? prq_pkg::CMD_POP :
                           (roll < 85) ? prq_pkg::CMD_INSERT :
                           (roll < 96) ? prq_pkg::CMD_PUSH : prq_pkg::CMD_NONE;
                    default: c = (roll < 40) ? prq_pkg::CMD_INSERT :
                                 (roll < 55) ? prq_pkg::CMD_PUSH :
                                 (roll < 95) ? prq_pkg::CMD_POP : prq_pkg::CMD_NONE;
                endcase
                roll = $urandom_range(0, 99);
                if (roll < 5)       p = 8'h00;
                else if (roll < 10) p = 8'hFF;
                else if (narrow_pri) p = 8'($urandom_range(pri_base, pri_base + 3));
                else                 p = 8'($urandom_range(0, 255));
                add_word(c, 16'($urandom_range(0, 65535)), p, pick_gap());
                if (c != prq_pkg::CMD_NONE) placed++;
            end
        end

        // Release reset on a falling edge, like every other input.
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every word has gone out and every prediction has been met, then let the
        // DRAIN_CYCLES quiet cycles pass.
        while (cmd_backlog.size() != 0 || start || predicted_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d inserts, %0d pushes, %0d pops (%0d on an empty queue), %0d unused",
                 n_inserts, n_pushes, n_pops, n_empty_pops, n_unused);
        $display("Queue reached full %0d times, %0d words refused, %0d results checked",
                 n_full_hits, n_drops, n_results);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
